@@ hw/rtl/door_pkg.sv @@
// door opener controller: shared types, codes and reset values
package door_pkg;

    // one input item
    typedef struct packed {
        logic action;
        logic button_level;
        logic open_limit;
        logic closed_limit;
        logic fault_level;
    } t_door_in;

    // one result item
    typedef struct packed {
        logic [2:0] door_state;
        logic [7:0] servo_position;
        logic       light_on;
        logic       state_changed;
    } t_door_out;

    // operating mode, one-hot
    typedef enum logic [5:0] {
        MODE_OPENED  = 6'b000001,
        MODE_CLOSED  = 6'b000010,
        MODE_OPENING = 6'b000100,
        MODE_CLOSING = 6'b001000,
        MODE_PAUSED  = 6'b010000,
        MODE_FAULTED = 6'b100000
    } t_mode;

    // door_state codes on the result
    localparam logic [2:0] DS_OPENED  = 3'd0;
    localparam logic [2:0] DS_CLOSED  = 3'd1;
    localparam logic [2:0] DS_OPENING = 3'd2;
    localparam logic [2:0] DS_CLOSING = 3'd3;
    localparam logic [2:0] DS_PAUSED  = 3'd4;
    localparam logic [2:0] DS_FAULTED = 3'd5;

    // action codes
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_REMOTE = 1'b1;

    // register indexes
    localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [2:0] REG_STEP_PER  = 3'd1;
    localparam logic [2:0] REG_BLINK_PER = 3'd2;
    localparam logic [2:0] REG_LIGHT_HLD = 3'd3;
    localparam logic [2:0] REG_SERVO_MIN = 3'd4;
    localparam logic [2:0] REG_SERVO_MAX = 3'd5;
    localparam logic [2:0] REG_SERVO_STP = 3'd6;

    // register reset values
    localparam logic [15:0] RST_DEBOUNCE  = 16'd100;
    localparam logic [15:0] RST_STEP_PER  = 16'd50;
    localparam logic [15:0] RST_BLINK_PER = 16'd500;
    localparam logic [15:0] RST_LIGHT_HLD = 16'd5000;
    localparam logic [7:0]  RST_SERVO_MIN = 8'd20;
    localparam logic [7:0]  RST_SERVO_MAX = 8'd160;
    localparam logic [7:0]  RST_SERVO_STP = 8'd5;

    // tracker slots
    localparam int NTRACK     = 6;
    localparam int TRK_OPEN   = 0;
    localparam int TRK_CLOSE  = 1;
    localparam int TRK_PAUSE  = 2;
    localparam int TRK_OPENED = 3;
    localparam int TRK_CLOSED = 4;
    localparam int TRK_MOVING = 5;

    // mode to result code
    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_OPENED:  c = DS_OPENED;
            MODE_CLOSED:  c = DS_CLOSED;
            MODE_OPENING: c = DS_OPENING;
            MODE_CLOSING: c = DS_CLOSING;
            MODE_PAUSED:  c = DS_PAUSED;
            MODE_FAULTED: c = DS_FAULTED;
            default:      c = DS_CLOSED;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/door_opener_controller.sv @@
// door opener controller: input register, mode logic and result register
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------
//  in       | to block  | i_in_valid / o_in_stall  | i_in_data  (t_door_in)
//  out      | from blk  | o_out_valid / i_out_stall| o_out_data (t_door_out)
//  config   | to block  | psel / penable / pready  | paddr, pwdata, prdata
//
// one item per clock sustained while the result is not stalled; an item waits in the input
// register and its result enters the result register when that register is free
// all mode, tracker, phase and timer logic sits between those two registers
// reset clears mode, trackers, timers and registers to their defaults
// a stalled result holds the pipe; the input register still takes a transfer
// while the result register is full but about to be taken
module door_opener_controller #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  door_pkg::t_door_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output door_pkg::t_door_out o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import door_pkg::*;

    localparam int CW = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

    // configuration registers
    logic [15:0] r_debounce, r_step_per, r_blink_per, r_light_hld;
    logic [7:0]  r_servo_min, r_servo_max, r_servo_stp;

    // pipeline
    logic      r_s1_valid, r_out_valid;
    t_door_in  r_s1_data;
    t_door_out r_out_data, n_out_data;
    logic      s2_free, s1_fire, in_take;

    // controller state
    t_mode                 r_mode, n_mode, r_prev, n_prev;
    logic [7:0]            r_pos, n_pos;
    logic                  r_lamp, n_lamp, r_latch, n_latch;
    logic [NTRACK-1:0]     r_last, n_last;
    logic [TIME_WIDTH-1:0] r_el [NTRACK];
    logic [TIME_WIDTH-1:0] n_el [NTRACK];
    logic [15:0]           r_step_ph, n_step_ph, r_blink_ph, n_blink_ph;
    logic [15:0]           r_hold_rem, n_hold_rem;
    logic                  r_hold_run, n_hold_run;

    // per-tick helpers
    logic [TIME_WIDTH-1:0] el_inc [NTRACK];
    logic [NTRACK-1:0]     lvl, fire, use_trk;
    logic [16:0]           step_nx, blink_nx;
    logic                  step_fire, blink_fire;
    logic                  wr_en;
    logic [2:0]            reg_idx;

    // handshakes
    assign s2_free     = !r_out_valid || !i_out_stall;
    assign s1_fire     = r_s1_valid && s2_free;
    assign o_in_stall  = r_s1_valid && !s2_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:  prdata = {16'd0, r_debounce};
            REG_STEP_PER:  prdata = {16'd0, r_step_per};
            REG_BLINK_PER: prdata = {16'd0, r_blink_per};
            REG_LIGHT_HLD: prdata = {16'd0, r_light_hld};
            REG_SERVO_MIN: prdata = {24'd0, r_servo_min};
            REG_SERVO_MAX: prdata = {24'd0, r_servo_max};
            REG_SERVO_STP: prdata = {24'd0, r_servo_stp};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= RST_DEBOUNCE;
            r_step_per  <= RST_STEP_PER;
            r_blink_per <= RST_BLINK_PER;
            r_light_hld <= RST_LIGHT_HLD;
            r_servo_min <= RST_SERVO_MIN;
            r_servo_max <= RST_SERVO_MAX;
            r_servo_stp <= RST_SERVO_STP;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DEBOUNCE:  r_debounce  <= pwdata[15:0];
                REG_STEP_PER:  r_step_per  <= pwdata[15:0];
                REG_BLINK_PER: r_blink_per <= pwdata[15:0];
                REG_LIGHT_HLD: r_light_hld <= pwdata[15:0];
                REG_SERVO_MIN: r_servo_min <= pwdata[7:0];
                REG_SERVO_MAX: r_servo_max <= pwdata[7:0];
                REG_SERVO_STP: r_servo_stp <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // tracker levels, saturating elapsed counts and debounce fire
    assign lvl = {r_s1_data.button_level, r_s1_data.button_level,
                  r_s1_data.button_level, r_s1_data.button_level,
                  r_s1_data.closed_limit, r_s1_data.open_limit};

    always_comb begin
        for (int i = 0; i < NTRACK; i++) begin
            el_inc[i] = (r_el[i] == {TIME_WIDTH{1'b1}}) ? r_el[i] : r_el[i] + 1'b1;
            fire[i]   = lvl[i] && (lvl[i] == r_last[i]) &&
                        (CW'(el_inc[i]) > CW'(r_debounce));
        end
    end

    // phase counters
    assign step_nx    = {1'b0, r_step_ph} + 17'd1;
    assign blink_nx   = {1'b0, r_blink_ph} + 17'd1;
    assign step_fire  = step_nx >= {1'b0, r_step_per};
    assign blink_fire = blink_nx >= {1'b0, r_blink_per};

    // next state for the item in the input register
    always_comb begin
        n_mode     = r_mode;
        n_prev     = r_prev;
        n_pos      = r_pos;
        n_lamp     = r_lamp;
        n_latch    = r_latch;
        n_step_ph  = r_step_ph;
        n_blink_ph = r_blink_ph;
        n_hold_rem = r_hold_rem;
        n_hold_run = r_hold_run;
        use_trk    = '0;

        if (r_s1_data.action == ACT_REMOTE) begin
            // remote press rules, time stands still
            unique case (r_mode) inside
                MODE_OPENING, MODE_CLOSING: begin
                    n_prev = r_mode;
                    n_mode = MODE_PAUSED;
                end
                MODE_OPENED: begin
                    n_prev = r_mode;
                    n_mode = MODE_CLOSING;
                end
                MODE_CLOSED: begin
                    n_prev = r_mode;
                    n_mode = MODE_OPENING;
                end
                MODE_PAUSED: begin
                    if (r_prev == MODE_OPENING) begin
                        n_prev = r_mode;
                        n_mode = MODE_CLOSING;
                    end else if (r_prev == MODE_CLOSING) begin
                        n_prev = r_mode;
                        n_mode = MODE_OPENING;
                    end
                end
                default: ;
            endcase
        end else begin
            // time base
            n_step_ph  = step_fire ? 16'd0 : step_nx[15:0];
            n_blink_ph = blink_fire ? 16'd0 : blink_nx[15:0];
            if (r_hold_run) begin
                if (r_hold_rem <= 16'd1) begin
                    n_hold_rem = 16'd0;
                    n_hold_run = 1'b0;
                    n_lamp     = 1'b0;
                end else begin
                    n_hold_rem = r_hold_rem - 16'd1;
                end
            end

            // mode logic
            unique case (r_mode)
                MODE_OPENING: begin
                    n_lamp = 1'b1;
                    if (step_fire) begin
                        n_pos = (r_pos == r_servo_max) ? r_servo_min : r_pos + r_servo_stp;
                    end
                    use_trk[TRK_OPEN] = 1'b1;
                    if (fire[TRK_OPEN]) begin
                        n_prev     = n_mode;
                        n_mode     = MODE_OPENED;
                        n_hold_rem = r_light_hld;
                        n_hold_run = 1'b1;
                    end
                    if (!r_s1_data.button_level) begin
                        n_latch = 1'b0;
                    end
                    use_trk[TRK_MOVING] = !n_latch;
                    if (!n_latch && fire[TRK_MOVING]) begin
                        n_latch    = 1'b1;
                        n_prev     = n_mode;
                        n_mode     = MODE_PAUSED;
                        n_hold_rem = r_light_hld;
                        n_hold_run = 1'b1;
                    end
                    if (r_s1_data.fault_level) begin
                        n_prev = n_mode;
                        n_mode = MODE_FAULTED;
                        n_lamp = 1'b1;
                    end
                end
                MODE_CLOSING: begin
                    n_lamp = 1'b1;
                    if (step_fire) begin
                        n_pos = (r_pos == r_servo_min) ? r_servo_max : r_pos - r_servo_stp;
                    end
                    use_trk[TRK_CLOSE] = 1'b1;
                    if (fire[TRK_CLOSE]) begin
                        n_prev     = n_mode;
                        n_mode     = MODE_CLOSED;
                        n_hold_rem = r_light_hld;
                        n_hold_run = 1'b1;
                    end
                    if (!r_s1_data.button_level) begin
                        n_latch = 1'b0;
                    end
                    use_trk[TRK_MOVING] = !n_latch;
                    if (!n_latch && fire[TRK_MOVING]) begin
                        n_latch    = 1'b1;
                        n_prev     = n_mode;
                        n_mode     = MODE_PAUSED;
                        n_hold_rem = r_light_hld;
                        n_hold_run = 1'b1;
                    end
                    // a fault while closing always records closing
                    if (r_s1_data.fault_level) begin
                        n_mode = MODE_FAULTED;
                        n_prev = MODE_CLOSING;
                    end
                end
                MODE_OPENED: begin
                    use_trk[TRK_OPENED] = 1'b1;
                    if (fire[TRK_OPENED]) begin
                        n_prev  = r_mode;
                        n_mode  = MODE_CLOSING;
                        n_latch = 1'b1;
                    end
                end
                MODE_CLOSED: begin
                    use_trk[TRK_CLOSED] = 1'b1;
                    if (fire[TRK_CLOSED]) begin
                        n_prev  = r_mode;
                        n_mode  = MODE_OPENING;
                        n_latch = 1'b1;
                    end
                end
                MODE_PAUSED: begin
                    if (!r_s1_data.button_level) begin
                        n_latch = 1'b0;
                    end
                    use_trk[TRK_PAUSE] = !n_latch;
                    if (!n_latch && fire[TRK_PAUSE]) begin
                        n_latch = 1'b1;
                        n_prev  = r_mode;
                        n_mode  = (r_prev == MODE_OPENING) ? MODE_CLOSING : MODE_OPENING;
                    end
                end
                MODE_FAULTED: begin
                    if (blink_fire) begin
                        n_lamp = !n_lamp;
                    end
                    if (!r_s1_data.button_level) begin
                        n_latch = 1'b0;
                    end
                    use_trk[TRK_PAUSE] = !n_latch;
                    if (!n_latch && fire[TRK_PAUSE]) begin
                        n_latch = 1'b1;
                        n_prev  = r_mode;
                        n_mode  = MODE_OPENING;
                    end
                end
                default: ;
            endcase
        end

        // tracker updates
        for (int i = 0; i < NTRACK; i++) begin
            if (r_s1_data.action == ACT_REMOTE) begin
                n_el[i]   = r_el[i];
                n_last[i] = r_last[i];
            end else begin
                n_el[i]   = (use_trk[i] && (lvl[i] != r_last[i])) ? '0 : el_inc[i];
                n_last[i] = use_trk[i] ? lvl[i] : r_last[i];
            end
        end

        // result item
        n_out_data.door_state     = mode_code(n_mode);
        n_out_data.servo_position = n_pos;
        n_out_data.light_on       = n_lamp;
        n_out_data.state_changed  = (n_mode != r_mode);
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_CLOSED;
            r_prev      <= MODE_CLOSED;
            r_pos       <= RST_SERVO_MIN;
            r_lamp      <= 1'b0;
            r_latch     <= 1'b0;
            r_last      <= '1;
            r_step_ph   <= 16'd0;
            r_blink_ph  <= 16'd0;
            r_hold_rem  <= 16'd0;
            r_hold_run  <= 1'b0;
            for (int i = 0; i < NTRACK; i++) begin
                r_el[i] <= '0;
            end
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_mode     <= n_mode;
                r_prev     <= n_prev;
                r_pos      <= n_pos;
                r_lamp     <= n_lamp;
                r_latch    <= n_latch;
                r_last     <= n_last;
                r_step_ph  <= n_step_ph;
                r_blink_ph <= n_blink_ph;
                r_hold_rem <= n_hold_rem;
                r_hold_run <= n_hold_run;
                for (int i = 0; i < NTRACK; i++) begin
                    r_el[i] <= n_el[i];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data <= i_in_data;
        end
        if (s1_fire) begin
            r_out_data <= n_out_data;
        end
    end

    // a held item in the input register is neither lost nor altered
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_free) |=> (r_s1_valid && $stable(r_s1_data)))
        else $error("input register lost or changed a held item");

    // a remote press leaves the time base alone
    a_remote_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_data.action == ACT_REMOTE) |=>
        ($stable(r_step_ph) && $stable(r_blink_ph) && $stable(r_hold_rem)))
        else $error("remote press moved the time base");

    // a remote press while faulted keeps the door faulted
    a_remote_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_data.action == ACT_REMOTE && r_mode == MODE_FAULTED) |=>
        (r_mode == MODE_FAULTED))
        else $error("remote press left the faulted mode");

    // light is lit after any tick spent opening
    a_light_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_data.action == ACT_TICK && r_mode == MODE_OPENING) |=> r_lamp)
        else $error("light off after an opening tick");

endmodule
